@@ src/appp_pkg.sv @@
// appp_pkg: shared types and constants of the alpha premultiply pixel packer
// no dependencies; imported by the top level and its port checker
`timescale 1ns / 1ps
`default_nettype none

package appp_pkg;

	localparam int MAX_SIDE = 256;
	localparam int SIDE_W   = $clog2(MAX_SIDE);
	localparam int DIM_W    = 9;
	localparam int CHAN_W   = 8;
	localparam int WORD_W   = 32;
	localparam int INDEX_W  = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_ORDER    = 2'd2;

	localparam logic [DIM_W-1:0] RESET_SIDE = DIM_W'(32);

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] alpha;
	} pixel_t;

	typedef struct packed {
		logic [WORD_W-1:0]  packed_pixel;
		logic [INDEX_W-1:0] pixel_index;
		logic               last_pixel;
	} result_t;

endpackage

`default_nettype wire

@@ src/alpha_premultiply_pixel_packer.sv @@
// alpha_premultiply_pixel_packer: straight-alpha rgba8 to premultiplied argb32 packer
// depends on appp_pkg for payload types, register codes and size constants
`timescale 1ns / 1ps
`default_nettype none

// channel  dir   payload                          request moves when
// -------  ----  -------------------------------  --------------------------
// pix      in    pixel_t  red green blue alpha    pix_valid && pix_ready
// res      out   result_t packed index last       res_valid && res_ready
// cfg      in    cfg_index, cfg_data               cfg_valid && cfg_ready
//
// one pixel per cycle sustained while res is not stalled; accept fills stage 1, then stage 2 holds the result
// stage 1 registers the pixel with its index (one 8x9 multiply on the counters)
// stage 2 registers the premultiplied word (three 8x8 multiplies, divide by 255)
// pix_ready drops only when both stages are full and res is stalled
// reset clears the counters and sets width/height 32, top-down row order
// cfg_ready is always high; any listed register write restarts the image

module alpha_premultiply_pixel_packer
	import appp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  pix_valid,
	output logic                       pix_ready,
	input  wire pixel_t                pix,
	output logic                       res_valid,
	input  wire logic                  res_ready,
	output result_t                    res,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	// rounded c*a/255, exact for all 8-bit inputs: t = c*a+128, (t + t>>8) >> 8
	function automatic logic [CHAN_W-1:0] premul(input logic [CHAN_W-1:0] c,
			input logic [CHAN_W-1:0] a);
		logic [2*CHAN_W-1:0] t;
		logic [2*CHAN_W-1:0] s;
		t = (2*CHAN_W)'(c) * (2*CHAN_W)'(a) + (2*CHAN_W)'(128);
		s = t + (t >> CHAN_W);
		return s[2*CHAN_W-1:CHAN_W];
	endfunction

	// configuration registers
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic             order_q;

	// source position counters
	logic [SIDE_W-1:0] col_q;
	logic [SIDE_W-1:0] row_q;

	// pipeline registers
	logic                v_s1;
	pixel_t              pix_s1;
	logic [INDEX_W-1:0]  idx_s1;
	logic                last_s1;
	logic                v_s2;
	result_t             res_s2;

	// clamped sizes, 1..MAX_SIDE
	logic [DIM_W-1:0]  w_eff;
	logic [DIM_W-1:0]  h_eff;
	logic [SIDE_W-1:0] w_last;
	logic [SIDE_W-1:0] h_last;
	logic [SIDE_W-1:0] dst_row;
	logic [INDEX_W-1:0] idx_full;
	logic              col_end;
	logic              row_end;

	logic adv_s2;
	logic adv_s1;
	logic pix_acc;
	logic cfg_hit;

	always_comb begin
		if (width_q == '0) begin
			w_eff = DIM_W'(1);
		end else if (width_q > DIM_W'(MAX_SIDE)) begin
			w_eff = DIM_W'(MAX_SIDE);
		end else begin
			w_eff = width_q;
		end
		if (height_q == '0) begin
			h_eff = DIM_W'(1);
		end else if (height_q > DIM_W'(MAX_SIDE)) begin
			h_eff = DIM_W'(MAX_SIDE);
		end else begin
			h_eff = height_q;
		end
	end

	assign w_last  = SIDE_W'(w_eff - DIM_W'(1));
	assign h_last  = SIDE_W'(h_eff - DIM_W'(1));
	assign col_end = (col_q == w_last);
	assign row_end = (row_q == h_last);

	// rows flipped for bottom-up storage
	assign dst_row  = order_q ? (h_last - row_q) : row_q;
	assign idx_full = INDEX_W'(dst_row) * INDEX_W'(w_eff) + INDEX_W'(col_q);

	// stall chain: each stage moves when the one after it has room
	assign adv_s2    = !v_s2 || res_ready;
	assign adv_s1    = !v_s1 || adv_s2;
	assign pix_ready = adv_s1;
	assign pix_acc   = pix_valid && pix_ready;

	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid && (cfg_index == REG_IMAGE_WIDTH
		|| cfg_index == REG_IMAGE_HEIGHT || cfg_index == REG_ROW_ORDER);

	// configuration and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RESET_SIDE;
			height_q <= RESET_SIDE;
			order_q  <= 1'b0;
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_hit) begin
			// a write restarts the image from the first pixel
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				REG_ROW_ORDER:    order_q  <= cfg_data[0];
				default:          order_q  <= order_q;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (pix_acc) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + SIDE_W'(1);
			end else begin
				col_q <= col_q + SIDE_W'(1);
			end
		end
	end

	// stage 1: pixel, destination index and end-of-image flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			pix_s1  <= pix;
			idx_s1  <= idx_full;
			last_s1 <= col_end && row_end;
		end
	end

	// stage 2: premultiply and pack into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			res_s2.packed_pixel <= {pix_s1.alpha,
				premul(pix_s1.red, pix_s1.alpha),
				premul(pix_s1.green, pix_s1.alpha),
				premul(pix_s1.blue, pix_s1.alpha)};
			res_s2.pixel_index  <= idx_s1;
			res_s2.last_pixel   <= last_s1;
		end
	end

	assign res_valid = v_s2;
	assign res       = res_s2;

endmodule

`default_nettype wire

@@ src/appp_checker.sv @@
// appp_checker: port-level assertions for alpha_premultiply_pixel_packer
// depends on appp_pkg; bound to the top level at the end of this file
`timescale 1ns / 1ps
`default_nettype none

module appp_checker
	import appp_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  pix_ready,
	input wire logic                  res_valid,
	input wire logic                  res_ready,
	input wire result_t               res
);

	// stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// empty output stage always leaves room for a new pixel
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> pix_ready)
		else $error("input blocked with empty output");

	// premultiplied channels never exceed alpha
	a_chan_le_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.packed_pixel[23:16] <= res.packed_pixel[31:24]
			&& res.packed_pixel[15:8] <= res.packed_pixel[31:24]
			&& res.packed_pixel[7:0] <= res.packed_pixel[31:24])
		else $error("channel above alpha");

	// transparent pixel has black color
	a_transparent: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.packed_pixel[31:24] == 8'd0 |-> res.packed_pixel[23:0] == 24'd0)
		else $error("color on transparent pixel");

endmodule

bind alpha_premultiply_pixel_packer appp_checker u_appp_checker (.*);

`default_nettype wire
